[rtl/core/fbpm_pkg.sv]
// Shared types and constants of the frame buffer pool manager.
package fbpm_pkg;

    localparam int MAX_FRAMES = 16;
    localparam int ID_W       = 4;
    localparam int CNT_W      = 5;

    localparam logic [2:0] CMD_NEW_FRAME    = 3'd0;
    localparam logic [2:0] CMD_TAKE_PROCESS = 3'd1;
    localparam logic [2:0] CMD_DONE_PROCESS = 3'd2;
    localparam logic [2:0] CMD_TAKE_RECORD  = 3'd3;
    localparam logic [2:0] CMD_DONE_RECORD  = 3'd4;

    localparam logic [1:0] REG_COUNT_EN   = 2'd0;
    localparam logic [1:0] REG_RECORD_EN  = 2'd1;
    localparam logic [1:0] REG_INIT_BUFS  = 2'd2;
    localparam logic [1:0] REG_MAX_BUFS   = 2'd3;

    localparam logic [CNT_W-1:0] INIT_BUFS_RST = 5'd4;
    localparam logic [CNT_W-1:0] MAX_BUFS_RST  = 5'd16;

    localparam int IN_W  = 8;
    localparam int OUT_W = 96;

    // Controller to datapath.
    typedef struct packed {
        logic load;        // capture input transaction
        logic scan_start;  // reset eviction scan
        logic scan_step;   // test one process queue entry
        logic commit;      // update state and load result register
    } fbpm_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic need_scan;
        logic scan_hit;
        logic scan_last;
        logic plen_nz;
    } fbpm_status_t;

    function automatic logic [CNT_W-1:0] clamp_pool(input logic [CNT_W-1:0] v);
        if (v == '0) begin
            return CNT_W'(1);
        end else if (v > CNT_W'(MAX_FRAMES)) begin
            return CNT_W'(MAX_FRAMES);
        end else begin
            return v;
        end
    endfunction

endpackage

[rtl/core/frame_buffer_pool_manager_top.sv]
// Frame buffer pool manager: hands out buffer ids to a producer and two consumers.
// Each command transaction yields one result. An accepted command goes through
// ST_CHECK and ST_EXEC, which registers the result once the output register is
// free; a new frame that finds the free stack empty at the growth limit with a
// nonempty process queue first scans it in ST_SCAN, one entry per cycle, for the
// oldest recorded frame. One command is handled at a time; a new command is
// accepted while the previous result still waits in the output register.
// Reset restores ids 0..3 on the free stack and empties both queues; no clearing pass.
module frame_buffer_pool_manager_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // command[2:0], buffer_id[6:3]
    output logic        m_tvalid,
    input  logic        m_tready,
    // id_valid[0], out_id[4:1], out_seq[36:5], evicted[37], evicted_id[41:38],
    // frame_lost[42], free_count[47:43], process_pending[52:48],
    // record_pending[57:53], drop_total[89:58]
    output logic [95:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import fbpm_pkg::*;

    fbpm_cmd_t    ctrl_cmd;
    fbpm_status_t dp_status;
    logic         cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    fbpm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (dp_status),
        .cmd      (ctrl_cmd)
    );

    fbpm_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (ctrl_cmd),
        .status    (dp_status),
        .in_data   (s_tdata),
        .out_data  (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_idx   (paddr[3:2]),
        .cfg_wdata (pwdata),
        .cfg_rdata (prdata)
    );

`ifndef SYNTHESIS
    a_commit_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_cmd.commit |-> (!m_tvalid || m_tready))
        else $error("result committed over a pending result");
    a_scan_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_cmd.scan_step |-> dp_status.plen_nz)
        else $error("eviction scan on empty process queue");
    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({ctrl_cmd.load, ctrl_cmd.scan_start, ctrl_cmd.scan_step, ctrl_cmd.commit}))
        else $error("conflicting datapath commands");
    a_result_after_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_cmd.commit |=> m_tvalid)
        else $error("commit without result");
`endif

endmodule

[rtl/core/fbpm_ctrl.sv]
// Sequencing state machine of the frame buffer pool manager.
module fbpm_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  fbpm_pkg::fbpm_status_t status,
    output fbpm_pkg::fbpm_cmd_t  cmd
);
    import fbpm_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_CHECK, ST_SCAN, ST_EXEC} state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;

    always_comb begin
        state_next     = state_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        cmd            = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (status.need_scan) begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end else begin
                    state_next = ST_EXEC;
                end
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (status.scan_hit || status.scan_last) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    cmd.commit   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

[rtl/core/fbpm_dp.sv]
// Datapath: config registers, free stack, consumer queues, flags and counters.
module fbpm_dp (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  fbpm_pkg::fbpm_cmd_t        cmd,
    output fbpm_pkg::fbpm_status_t     status,
    input  logic [fbpm_pkg::IN_W-1:0]  in_data,
    output logic [fbpm_pkg::OUT_W-1:0] out_data,
    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_idx,
    input  logic [31:0]                cfg_wdata,
    output logic [31:0]                cfg_rdata
);
    import fbpm_pkg::*;

    logic             count_en_reg, record_en_reg;
    logic [CNT_W-1:0] init_bufs_reg, max_bufs_reg;

    logic [ID_W-1:0]  fs_reg [MAX_FRAMES];
    logic [ID_W-1:0]  pq_reg [MAX_FRAMES];
    logic [ID_W-1:0]  rq_reg [MAX_FRAMES];
    logic [CNT_W-1:0] ft_reg, ft_next;
    logic [CNT_W-1:0] plen_reg, plen_next;
    logic [CNT_W-1:0] rlen_reg, rlen_next;
    logic [ID_W-1:0]  rhead_reg, rhead_next;
    logic [MAX_FRAMES-1:0] pflag_reg, rflag_reg;
    logic [CNT_W-1:0] alloc_reg, alloc_next;
    logic [31:0]      seq_reg, seq_next;
    logic [31:0]      drops_reg, drops_next;

    logic [2:0]       cmd_reg;
    logic [ID_W-1:0]  bid_reg;
    logic [ID_W-1:0]  scan_idx_reg;
    logic             found_reg;
    logic [OUT_W-1:0] out_reg;

    logic [CNT_W-1:0] lim, lim_max, lim_ini;
    logic             new_frame, en, grow, evict, have_free, assign_id, lost;
    logic [ID_W-1:0]  new_id, out_id;
    logic             pop_p, pop_r, remove_p, app_p, app_r, rel, pf_new, rf_new, push;
    logic [ID_W-1:0]  rm_idx;
    logic [CNT_W-1:0] plen_rm, ft_m1;
    logic [ID_W-1:0]  rtail;
    logic             id_valid;

    // effective growth limit
    always_comb begin
        lim_max = clamp_pool(max_bufs_reg);
        lim_ini = clamp_pool(init_bufs_reg);
        lim     = (lim_ini > lim_max) ? lim_ini : lim_max;
    end

    assign new_frame = (cmd_reg == CMD_NEW_FRAME);
    assign en        = count_en_reg || record_en_reg;
    assign have_free = (ft_reg != '0);
    assign ft_m1     = ft_reg - CNT_W'(1);
    assign grow      = new_frame && en && !have_free && (alloc_reg < lim);
    assign evict     = new_frame && en && !have_free && !grow && found_reg;
    assign assign_id = new_frame && en && (have_free || grow || evict);
    assign lost      = new_frame && en && !assign_id;

    assign status.need_scan = new_frame && en && !have_free && (alloc_reg >= lim)
                              && (plen_reg != '0);
    assign status.scan_hit  = rflag_reg[pq_reg[scan_idx_reg]];
    assign status.scan_last = ({1'b0, scan_idx_reg} + CNT_W'(1)) >= plen_reg;
    assign status.plen_nz   = (plen_reg != '0);

    always_comb begin
        if (have_free) begin
            new_id = fs_reg[ft_m1[ID_W-1:0]];
        end else if (grow) begin
            new_id = alloc_reg[ID_W-1:0];
        end else begin
            new_id = pq_reg[scan_idx_reg];
        end
    end

    assign pop_p    = (cmd_reg == CMD_TAKE_PROCESS) && (plen_reg != '0);
    assign pop_r    = (cmd_reg == CMD_TAKE_RECORD) && (rlen_reg != '0);
    assign remove_p = pop_p || evict;
    assign rm_idx   = evict ? scan_idx_reg : '0;
    assign plen_rm  = remove_p ? plen_reg - CNT_W'(1) : plen_reg;
    assign app_p    = assign_id && count_en_reg && (plen_rm < CNT_W'(MAX_FRAMES));
    assign app_r    = assign_id && record_en_reg && (rlen_reg < CNT_W'(MAX_FRAMES));
    assign rtail    = rhead_reg + rlen_reg[ID_W-1:0];

    assign rel    = ((cmd_reg == CMD_DONE_PROCESS) || (cmd_reg == CMD_DONE_RECORD))
                    && ({1'b0, bid_reg} < alloc_reg);
    assign pf_new = (cmd_reg == CMD_DONE_PROCESS) ? 1'b1 : pflag_reg[bid_reg];
    assign rf_new = (cmd_reg == CMD_DONE_RECORD) ? 1'b1 : rflag_reg[bid_reg];
    assign push   = rel && pf_new && rf_new && (ft_reg < CNT_W'(MAX_FRAMES));

    assign id_valid = assign_id || pop_p || pop_r;

    always_comb begin
        if (assign_id) begin
            out_id = new_id;
        end else if (pop_p) begin
            out_id = pq_reg[0];
        end else if (pop_r) begin
            out_id = rq_reg[rhead_reg];
        end else begin
            out_id = '0;
        end
    end

    always_comb begin
        ft_next = ft_reg;
        if (assign_id && have_free) begin
            ft_next = ft_m1;
        end else if (push) begin
            ft_next = ft_reg + CNT_W'(1);
        end
        plen_next  = app_p ? plen_rm + CNT_W'(1) : plen_rm;
        rlen_next  = rlen_reg + CNT_W'(app_r) - CNT_W'(pop_r);
        rhead_next = pop_r ? rhead_reg + ID_W'(1) : rhead_reg;
        alloc_next = grow ? alloc_reg + CNT_W'(1) : alloc_reg;
        seq_next   = new_frame ? seq_reg + 32'd1 : seq_reg;
        drops_next = drops_reg + 32'(evict || lost);
    end

    always_comb begin
        cfg_rdata = '0;
        case (cfg_idx)
            REG_COUNT_EN:  cfg_rdata = {31'd0, count_en_reg};
            REG_RECORD_EN: cfg_rdata = {31'd0, record_en_reg};
            REG_INIT_BUFS: cfg_rdata = {27'd0, init_bufs_reg};
            REG_MAX_BUFS:  cfg_rdata = {27'd0, max_bufs_reg};
            default:       cfg_rdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_en_reg  <= 1'b0;
            record_en_reg <= 1'b0;
            init_bufs_reg <= INIT_BUFS_RST;
            max_bufs_reg  <= MAX_BUFS_RST;
        end else if (cfg_we) begin
            case (cfg_idx)
                REG_COUNT_EN:  count_en_reg  <= cfg_wdata[0];
                REG_RECORD_EN: record_en_reg <= cfg_wdata[0];
                REG_INIT_BUFS: init_bufs_reg <= cfg_wdata[CNT_W-1:0];
                REG_MAX_BUFS:  max_bufs_reg  <= cfg_wdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // control and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ft_reg    <= clamp_pool(INIT_BUFS_RST);
            alloc_reg <= clamp_pool(INIT_BUFS_RST);
            plen_reg  <= '0;
            rlen_reg  <= '0;
            rhead_reg <= '0;
            pflag_reg <= '0;
            rflag_reg <= '0;
            seq_reg   <= '0;
            drops_reg <= '0;
            found_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                found_reg <= 1'b0;
            end
            if (cmd.scan_step && status.scan_hit) begin
                found_reg <= 1'b1;
            end
            if (cmd.commit) begin
                ft_reg    <= ft_next;
                alloc_reg <= alloc_next;
                plen_reg  <= plen_next;
                rlen_reg  <= rlen_next;
                rhead_reg <= rhead_next;
                seq_reg   <= seq_next;
                drops_reg <= drops_next;
                if (assign_id) begin
                    pflag_reg[new_id] <= !count_en_reg;
                    rflag_reg[new_id] <= !record_en_reg;
                end
                if (rel && (cmd_reg == CMD_DONE_PROCESS)) begin
                    pflag_reg[bid_reg] <= 1'b1;
                end
                if (rel && (cmd_reg == CMD_DONE_RECORD)) begin
                    rflag_reg[bid_reg] <= 1'b1;
                end
            end
        end
    end

    // free stack holds ids 0..15 after reset; only the first entries are live
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_FRAMES; i++) begin
                fs_reg[i] <= ID_W'(i);
            end
        end else if (cmd.commit && push) begin
            fs_reg[ft_reg[ID_W-1:0]] <= bid_reg;
        end
    end

    // payload: captured item, scan index, queues, result
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg <= in_data[2:0];
            bid_reg <= in_data[6:3];
        end
        if (cmd.scan_start) begin
            scan_idx_reg <= '0;
        end else if (cmd.scan_step && !status.scan_hit && !status.scan_last) begin
            scan_idx_reg <= scan_idx_reg + ID_W'(1);
        end
        if (cmd.commit) begin
            for (int j = 0; j < MAX_FRAMES; j++) begin
                if (app_p && (plen_rm[ID_W-1:0] == ID_W'(j))) begin
                    pq_reg[j] <= new_id;
                end else if (remove_p && (ID_W'(j) >= rm_idx) && (j < MAX_FRAMES - 1)) begin
                    pq_reg[j] <= pq_reg[(j + 1) % MAX_FRAMES];
                end
            end
            if (app_r) begin
                rq_reg[rtail] <= new_id;
            end
            out_reg <= {6'd0, drops_next, rlen_next, plen_next, ft_next, lost,
                        evict ? pq_reg[scan_idx_reg] : ID_W'(0), evict,
                        new_frame ? seq_reg : 32'd0, out_id, id_valid};
        end
    end

    assign out_data = out_reg;

endmodule
